// ===== hdl/copb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// copb_pkg
// Shared types and constants of the constant-opacity pixel blender.
// ----------------------------------------------------------------------------
package copb_pkg;

  localparam int PIXEL_W     = 32;
  localparam int CHAN_W      = 8;
  localparam int MATTE_W     = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [31:0] MASK_RB  = 32'h00ff00ff;
  localparam logic [31:0] MASK_G   = 32'h0000ff00;
  localparam logic [31:0] MASK_A   = 32'hff000000;
  localparam logic [7:0]  CHAN_MAX = 8'hff;

  // blend modes
  typedef enum logic [1:0] {
    MODE_PLAIN      = 2'd0,
    MODE_KEEP_ALPHA = 2'd1,
    MODE_ADDITIVE   = 2'd2,
    MODE_MATTE      = 2'd3
  } blend_mode_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLEND_MODE  = 2'd0,
    REG_OPACITY     = 2'd1,
    REG_MATTE_COLOR = 2'd2
  } cfg_reg_t;

endpackage

// ===== hdl/constant_opacity_pixel_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_opacity_pixel_blend
// Three-stage pipelined ARGB8888 blender with a constant source opacity.
// ----------------------------------------------------------------------------
// usage
//   input: a source and a destination pixel plus the span-end flag are taken
//   at a rising edge where start is high and busy is low; busy only rises
//   while rst is held, so a new transaction can be taken in every cycle
//   output: one blended pixel per transaction, shown for exactly one cycle
//   with result_valid high; the receiver has no way to hold it off, so the
//   pipeline never stalls and needs no skid storage
//   path: a transaction taken at an edge passes three register stages
//   (operand prep, multiply, combine) before its result shows
//   throughput: one pixel per clock
//   configuration: blend_mode, opacity and matte_color are written over the
//   cfg channel (always ready); writes are expected only while no pixel is
//   in flight; an index beyond the register list is ignored
//   reset: synchronous rst empties the pipeline and restores mode plain
//   blend, opacity 0xff and a black matte
// ----------------------------------------------------------------------------
module constant_opacity_pixel_blend (
  input  logic                               clk,
  input  logic                               rst,
  // pixel command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [copb_pkg::PIXEL_W-1:0]       src_pixel,
  input  logic [copb_pkg::PIXEL_W-1:0]       dst_pixel,
  input  logic                               last_pixel,
  // result channel
  output logic                               result_valid,
  output logic [copb_pkg::PIXEL_W-1:0]       out_pixel,
  output logic                               out_last,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [copb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [copb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import copb_pkg::*;

  // configuration registers
  blend_mode_t        blend_mode;
  logic [7:0]         opacity;
  logic [MATTE_W-1:0] matte_color;

  logic accept;

  // stage 1: operands
  logic        valid1;
  logic        last1;
  blend_mode_t mode1;
  logic [31:0] diff_rb1;
  logic [31:0] diff_g1;
  logic [31:0] bm_rb1;
  logic [31:0] bm_g1;
  logic [7:0]  f1;
  logic [2:0][7:0] src_ch1;
  logic [2:0][7:0] dst_ch1;
  logic [7:0]  dst_a1;
  logic [7:0]  op1;

  // stage 1 combinational operand selection
  logic [31:0] lerp_a;
  logic [31:0] lerp_b;
  logic [7:0]  lerp_f;

  // stage 2: products
  logic        valid2;
  logic        last2;
  blend_mode_t mode2;
  logic [31:0] prod_rb2;
  logic [31:0] prod_g2;
  logic [31:0] bm_rb2;
  logic [31:0] bm_g2;
  logic [2:0][15:0] src_prod2;
  logic [2:0][15:0] dst_prod2;
  logic [15:0] alpha_prod2;
  logic [7:0]  dst_a2;
  logic [7:0]  op2;

  // stage 3 combinational combine
  logic [31:0] lerp_rb;
  logic [31:0] lerp_g;
  logic [31:0] lerp_px;
  logic [2:0][8:0] ch_sum;
  logic [2:0][7:0] ch_sat;
  logic [8:0]  na_raw;
  logic [8:0]  na_fix;
  logic [31:0] result_next;

  // the pipeline never stalls, so only reset holds off new transactions
  assign busy      = rst;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode  <= MODE_PLAIN;
      opacity     <= CHAN_MAX;
      matte_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLEND_MODE:  blend_mode  <= blend_mode_t'(cfg_data[1:0]);
        REG_OPACITY:     opacity     <= cfg_data[7:0];
        REG_MATTE_COLOR: matte_color <= cfg_data[MATTE_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: pick lerp operands and form the packed differences
  // --------------------------------------------------------------------------
  // matte lerps dst over the matte color by dst alpha, the other modes
  // lerp src over dst by the opacity
  always_comb begin
    if (blend_mode == MODE_MATTE) begin
      lerp_a = dst_pixel;
      lerp_b = {8'd0, matte_color};
      lerp_f = dst_pixel[31:24];
    end else begin
      lerp_a = src_pixel;
      lerp_b = dst_pixel;
      lerp_f = opacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last1    <= last_pixel;
      mode1    <= blend_mode;
      // packed differences wrap modulo 2^32 when negative
      diff_rb1 <= (lerp_a & MASK_RB) - (lerp_b & MASK_RB);
      diff_g1  <= (lerp_a & MASK_G) - (lerp_b & MASK_G);
      bm_rb1   <= lerp_b & MASK_RB;
      bm_g1    <= lerp_b & MASK_G;
      f1       <= lerp_f;
      src_ch1  <= src_pixel[23:0];
      dst_ch1  <= dst_pixel[23:0];
      dst_a1   <= dst_pixel[31:24];
      op1      <= opacity;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: multiplies
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (valid1) begin
      last2    <= last1;
      mode2    <= mode1;
      // packed lerp products keep only the low 32 bits
      prod_rb2 <= diff_rb1 * {24'd0, f1};
      prod_g2  <= diff_g1 * {24'd0, f1};
      bm_rb2   <= bm_rb1;
      bm_g2    <= bm_g1;
      for (int i = 0; i < 3; i++) begin
        // premultiplied source and inverse-scaled destination channels
        src_prod2[i] <= {8'd0, src_ch1[i]} * {8'd0, op1};
        dst_prod2[i] <= {8'd0, dst_ch1[i]} * {8'd0, op1 ^ CHAN_MAX};
      end
      alpha_prod2 <= {8'd0, dst_a1} * {8'd0, op1};
      dst_a2      <= dst_a1;
      op2         <= op1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: combine and select by mode
  // --------------------------------------------------------------------------
  always_comb begin
    lerp_rb = (bm_rb2 + {8'd0, prod_rb2[31:8]}) & MASK_RB;
    lerp_g  = (bm_g2 + {8'd0, prod_g2[31:8]}) & MASK_G;
    lerp_px = lerp_rb | lerp_g;

    // per-channel saturating add of the two scaled pixels
    for (int i = 0; i < 3; i++) begin
      ch_sum[i] = {1'b0, src_prod2[i][15:8]} + {1'b0, dst_prod2[i][15:8]};
      ch_sat[i] = ch_sum[i][8] ? CHAN_MAX : ch_sum[i][7:0];
    end

    // merged alpha a + o - a*o/256, then folded back below 256
    na_raw = {1'b0, dst_a2} + {1'b0, op2} - {1'b0, alpha_prod2[15:8]};
    na_fix = na_raw - {8'd0, na_raw[8]};

    unique case (mode2)
      MODE_PLAIN:      result_next = lerp_px;
      MODE_KEEP_ALPHA: result_next = lerp_px | {dst_a2, 24'd0};
      MODE_ADDITIVE:   result_next = {na_fix[7:0], ch_sat};
      MODE_MATTE:      result_next = lerp_px | MASK_A;
      default:         result_next = lerp_px;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (valid2) begin
      out_pixel <= result_next;
      out_last  <= last2;
    end
  end

endmodule

// ===== test/tb_constant_opacity_pixel_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_constant_opacity_pixel_blend
// Self-checking bench for the constant-opacity ARGB8888 pixel blender. A
// scoreboard predicts every blended pixel from its own copy of the mode,
// opacity and matte registers. A monitor feeds it each accepted pixel and
// checks each strobed result against the oldest prediction. Stimulus runs
// corner pixels in every mode, then random phases. Each phase has its own
// register setting and its own sender idle rate.
// ----------------------------------------------------------------------------
module tb_constant_opacity_pixel_blend;
  import copb_pkg::*;

  // pipeline depth given by the block, used for the settle pause after a drain
  localparam int LATENCY = 3;
  localparam int PHASES = 12;
  localparam int PIXELS_PER_PHASE = 111;
  // index past the end of the register map, the block must ignore it
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  // --------------------------------------------------------------------------
  // scoreboard: register copy, blend predictor and queue of predicted pixels
  // --------------------------------------------------------------------------
  class pixel_blend_scoreboard;
    blend_mode_t mode;
    logic [CHAN_W-1:0] opacity;
    logic [MATTE_W-1:0] matte;
    logic [PIXEL_W:0] queued_pixels[$];  // {last, pixel}
    int mismatches;

    function new();
      mode = MODE_PLAIN;
      opacity = CHAN_MAX;
      matte = '0;
      mismatches = 0;
    endfunction

    function void update_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BLEND_MODE: mode = blend_mode_t'(data[1:0]);
        REG_OPACITY: opacity = data[CHAN_W-1:0];
        REG_MATTE_COLOR: matte = data[MATTE_W-1:0];
        default: ;
      endcase
    endfunction

    // channels selected by the mask: (b + ((a - b) * f >> 8)) & mask, wrapping at 32 bits
    function logic [31:0] lerp_lanes(logic [31:0] a, logic [31:0] b, logic [31:0] f,
                                     logic [31:0] mask);
      logic [31:0] diff, prod;
      diff = (a & mask) - (b & mask);
      prod = diff * f;
      return ((b & mask) + (prod >> 8)) & mask;
    endfunction

    function logic [31:0] additive_blend(logic [31:0] s, logic [31:0] d, logic [31:0] sa);
      logic [31:0] pre, b, da, na, inv, a, t, sum;
      // source premultiplied by opacity
      pre = (((s & MASK_G) * sa) & 32'h00ff0000) + (((s & MASK_RB) * sa) & 32'hff00ff00);
      b = (pre >> 8) & ~MASK_A;
      // merged alpha, then minus its bit 8
      da = d >> 24;
      na = da + sa - ((da * sa) >> 8);
      na = (na - (na >> 8)) & {24'd0, CHAN_MAX};
      // destination scaled by the inverse opacity
      inv = sa ^ {24'd0, CHAN_MAX};
      a = ((((d & MASK_RB) * inv) >> 8) & MASK_RB) + ((((d & MASK_G) * inv) >> 8) & MASK_G);
      // per-byte saturating add
      t = ((a & b) + (((a ^ b) >> 1) & 32'h7f7f7f7f)) & 32'h80808080;
      t = (t << 1) - (t >> 7);
      sum = (a + b - t) | t;
      return (sum & ~MASK_A) | (na << 24);
    endfunction

    function logic [31:0] blend_pixel(logic [31:0] s, logic [31:0] d);
      logic [31:0] f, c;
      f = {24'd0, opacity};
      c = {8'd0, matte};
      case (mode)
        MODE_PLAIN: return lerp_lanes(s, d, f, MASK_RB) | lerp_lanes(s, d, f, MASK_G);
        MODE_KEEP_ALPHA:
          return lerp_lanes(s, d, f, MASK_RB) | lerp_lanes(s, d, f, MASK_G) | (d & MASK_A);
        MODE_ADDITIVE: return additive_blend(s, d, f);
        default:
          return lerp_lanes(d, c, d >> 24, MASK_RB) | lerp_lanes(d, c, d >> 24, MASK_G) | MASK_A;
      endcase
    endfunction

    function void note_pixel(logic [31:0] s, logic [31:0] d, logic last);
      queued_pixels.push_back({last, blend_pixel(s, d)});
    endfunction

    function int pending();
      return queued_pixels.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t mode=%0d opacity=%h matte=%h: %s",
               $time, mode, opacity, matte, msg);
      mismatches++;
    endtask

    task check_result(logic [31:0] pixel, logic last);
      logic [PIXEL_W:0] want;
      if (queued_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel=%h last=%b", pixel, last));
      end else begin
        want = queued_pixels.pop_front();
        if (pixel !== want[PIXEL_W-1:0])
          report_mismatch($sformatf("out_pixel %h, predicted %h", pixel, want[PIXEL_W-1:0]));
        if (last !== want[PIXEL_W])
          report_mismatch($sformatf("out_last %b, predicted %b", last, want[PIXEL_W]));
      end
    endtask

    task report_leftovers();
      if (queued_pixels.size() != 0)
        report_mismatch($sformatf("%0d predicted results never arrived", queued_pixels.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports; the driven inputs are known from time zero
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [PIXEL_W-1:0] src_pixel = '0;
  logic [PIXEL_W-1:0] dst_pixel = '0;
  logic last_pixel = 1'b0;
  logic result_valid;
  logic [PIXEL_W-1:0] out_pixel;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // percentage of cycles in which the sender holds back before a pixel
  int sender_idle_pct = 0;

  pixel_blend_scoreboard board = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  constant_opacity_pixel_blend dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .src_pixel    (src_pixel),
    .dst_pixel    (dst_pixel),
    .last_pixel   (last_pixel),
    .result_valid (result_valid),
    .out_pixel    (out_pixel),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // monitor: samples pre-edge values, so it never races the drivers below
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      // register write transaction updates the predictor's copy
      if (cfg_valid && cfg_ready)
        board.update_register(cfg_index, cfg_data);
      // pixel transaction accepted: predict its blend
      if (start && !busy)
        board.note_pixel(src_pixel, dst_pixel, last_pixel);
      // result strobe: exactly one cycle, nothing can hold it off
      if (result_valid)
        board.check_result(out_pixel, out_last);
    end
  end

  // --------------------------------------------------------------------------
  // drivers: every task returns in the time step of the edge that took its
  // transaction, and never assigns a signal twice in one step
  // --------------------------------------------------------------------------

  // one pixel transaction, after a random number of idle cycles
  task automatic send_pixel(input logic [31:0] s, input logic [31:0] d, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    src_pixel <= s;
    dst_pixel <= d;
    last_pixel <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // one register write transaction; the caller lowers cfg_valid afterwards
  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop sending and wait until every predicted pixel has come back
  task automatic drain_pipeline();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (board.pending() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    // then settle past the pipeline depth
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic configure(input blend_mode_t m, input logic [CHAN_W-1:0] op,
                           input logic [MATTE_W-1:0] matte);
    logic [CFG_DATA_W-1:0] noise;
    drain_pipeline();
    noise = CFG_DATA_W'($urandom);
    // unused upper data bits carry noise, the registers take only their width
    set_register(REG_BLEND_MODE, {noise[CFG_DATA_W-1:2], m});
    set_register(REG_OPACITY, {noise[CFG_DATA_W-1:CHAN_W], op});
    set_register(REG_MATTE_COLOR, matte);
    // a write to an unmapped index must leave every register alone
    noise = CFG_DATA_W'($urandom);
    set_register(REG_NONE, noise);
    cfg_valid <= 1'b0;
  endtask

  // extremes, the source alpha ignored outside the matte mode, span end both ways
  task automatic send_corner_pixels();
    send_pixel(32'h00000000, 32'hffffffff, 1'b0);
    send_pixel(32'hffffffff, 32'h00000000, 1'b1);
    send_pixel(32'hffffffff, 32'hffffffff, 1'b0);
    send_pixel(32'h00abcdef, 32'h80123456, 1'b1);
    send_pixel(32'hffabcdef, 32'h80123456, 1'b0);
  endtask

  // bytes biased toward 00 and ff so saturation and wraparound get hit
  function automatic logic [31:0] random_pixel();
    logic [31:0] p;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0: p[i*8 +: 8] = 8'h00;
        1: p[i*8 +: 8] = 8'hff;
        default: p[i*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] random_opacity();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [23:0] random_matte();
    case ($urandom_range(0, 3))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom_range(0, 24'hffffff));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values first, then each mode, with extreme opacity outside matte
    send_corner_pixels();
    configure(MODE_KEEP_ALPHA, 8'h00, 24'h000000);
    send_corner_pixels();
    configure(MODE_ADDITIVE, 8'hff, 24'h000000);
    send_corner_pixels();
    configure(MODE_ADDITIVE, 8'h00, 24'hffffff);
    send_corner_pixels();
    configure(MODE_MATTE, 8'h5a, 24'hffffff);
    send_corner_pixels();

    // random phases: every mode meets every sender idle rate once
    for (int phase = 0; phase < PHASES; phase++) begin
      configure(blend_mode_t'(phase % 4), random_opacity(), random_matte());
      case (phase % 3)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 56;
        default: sender_idle_pct = 38;
      endcase
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        send_pixel(random_pixel(), random_pixel(), $urandom_range(0, 15) == 0);
        // now and then the sender waits for the pipeline to empty
        if ($urandom_range(0, 199) == 0)
          drain_pipeline();
      end
    end

    drain_pipeline();
    board.report_leftovers();
    if (board.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/copb_pkg.sv
hdl/constant_opacity_pixel_blend.sv
test/tb_constant_opacity_pixel_blend.sv
